FILE: sv/rfx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfx_pkg: shared types and constants of the register file ALU executor
// Holds the transaction structs, operation codes and the request/response
// structs used between the sequencer, the register file and the shared unit.
// ----------------------------------------------------------------------------
package rfx_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 4;
  localparam int REG_IDX_W    = 2;
  localparam int NUM_REGS_DEF = 4;

  localparam logic [OP_W-1:0] OP_LOAD     = 4'd0;
  localparam logic [OP_W-1:0] OP_MOVE     = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD      = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB      = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL      = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV      = 4'd5;
  localparam logic [OP_W-1:0] OP_MOD      = 4'd6;
  localparam logic [OP_W-1:0] OP_AND      = 4'd7;
  localparam logic [OP_W-1:0] OP_OR       = 4'd8;
  localparam logic [OP_W-1:0] OP_XOR      = 4'd9;
  localparam logic [OP_W-1:0] OP_EXCHANGE = 4'd10;
  localparam logic [OP_W-1:0] OP_OUTPUT   = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [REG_IDX_W-1:0]   dest_reg;
    logic [REG_IDX_W-1:0]   first_src;
    logic [REG_IDX_W-1:0]   second_src;
    logic signed [DATA_W-1:0] immediate;
  } rfx_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_print;
    logic                     divide_by_zero;
  } rfx_out_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] waddr;
    logic [DATA_W-1:0]    wdata;
    logic [REG_IDX_W-1:0] raddr0;
    logic [REG_IDX_W-1:0] raddr1;
  } rf_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata0;
    logic [DATA_W-1:0] rdata1;
  } rf_rsp_t;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic              want_rem;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
  } mdu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } mdu_rsp_t;

endpackage

FILE: sv/rfx_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfx_regs: register file
// One write port and two read ports with registered read data. Per-entry
// valid bits make every register read as zero after reset.
// ----------------------------------------------------------------------------
module rfx_regs #(
  parameter int NUM_REGS = rfx_pkg::NUM_REGS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rfx_pkg::rf_req_t req,
  output rfx_pkg::rf_rsp_t rsp
);
  import rfx_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CMP_W = ((IDX_W > REG_IDX_W) ? IDX_W : REG_IDX_W) + 1;

  logic [DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  logic [CMP_W-1:0] wide_w, wide_r0, wide_r1;
  logic [IDX_W-1:0] widx, ridx0, ridx1;
  logic             w_ok, r0_ok, r1_ok;

  // Indexes at or above the register count read as zero and drop writes.
  always_comb begin
    wide_w  = CMP_W'(req.waddr);
    wide_r0 = CMP_W'(req.raddr0);
    wide_r1 = CMP_W'(req.raddr1);
    widx    = wide_w[IDX_W-1:0];
    ridx0   = wide_r0[IDX_W-1:0];
    ridx1   = wide_r1[IDX_W-1:0];
    w_ok    = wide_w  < CMP_W'(NUM_REGS);
    r0_ok   = wide_r0 < CMP_W'(NUM_REGS);
    r1_ok   = wide_r1 < CMP_W'(NUM_REGS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we && w_ok) begin
      vld[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we && w_ok) begin
      mem[widx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rsp.rdata0 <= (r0_ok && vld[ridx0]) ? mem[ridx0] : '0;
    rsp.rdata1 <= (r1_ok && vld[ridx1]) ? mem[ridx1] : '0;
  end

endmodule

FILE: sv/rfx_mdu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfx_mdu: shared multiply/divide unit
// One 33-bit adder, stepped one bit per cycle: shift-add multiply (low 32
// bits) or restoring signed divide on magnitudes with a final sign fix.
// ----------------------------------------------------------------------------
module rfx_mdu (
  input  logic              clk,
  input  logic              rst,
  input  rfx_pkg::mdu_req_t req,
  output rfx_pkg::mdu_rsp_t rsp
);
  import rfx_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_RUN  = 3'b010,
    U_FIX  = 3'b100
  } ustate_t;

  ustate_t state;

  logic              is_div, want_rem, neg_q, neg_r, done;
  logic [DATA_W:0]   acc;
  logic [DATA_W-1:0] aux, opnd, result, fix_val, abs_a, abs_b;
  logic [CNT_W-1:0]  cnt;

  logic [DATA_W:0]   add_a, add_b, rem_sh;
  logic              add_cin, ge;
  logic [DATA_W+1:0] sum;

  always_comb begin
    abs_a  = req.opa[DATA_W-1] ? -req.opa : req.opa;
    abs_b  = req.opb[DATA_W-1] ? -req.opb : req.opb;
    rem_sh = {acc[DATA_W-1:0], aux[DATA_W-1]};
    if (is_div) begin
      add_a   = rem_sh;
      add_b   = ~{1'b0, opnd};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, acc[DATA_W-1:0]};
      add_b   = aux[0] ? {1'b0, opnd} : '0;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + (DATA_W + 2)'(add_cin);
    // The carry out says the shifted remainder is at least the divisor.
    ge  = sum[DATA_W+1];

    if (!is_div) begin
      fix_val = acc[DATA_W-1:0];
    end else if (want_rem) begin
      fix_val = neg_r ? -acc[DATA_W-1:0] : acc[DATA_W-1:0];
    end else begin
      fix_val = neg_q ? -aux : aux;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) state <= U_RUN;
        end
        U_RUN: begin
          if (cnt == CNT_W'(DATA_W - 1)) state <= U_FIX;
        end
        U_FIX: begin
          state <= U_IDLE;
          done  <= 1'b1;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (req.start) begin
          is_div   <= req.is_div;
          want_rem <= req.want_rem;
          neg_q    <= req.opa[DATA_W-1] ^ req.opb[DATA_W-1];
          neg_r    <= req.opa[DATA_W-1];
          acc      <= '0;
          cnt      <= '0;
          if (req.is_div) begin
            aux  <= abs_a;
            opnd <= abs_b;
          end else begin
            aux  <= req.opb;
            opnd <= req.opa;
          end
        end
      end
      U_RUN: begin
        cnt <= cnt + CNT_W'(1);
        if (is_div) begin
          acc <= ge ? sum[DATA_W:0] : rem_sh;
          aux <= {aux[DATA_W-2:0], ge};
        end else begin
          acc  <= sum[DATA_W:0];
          opnd <= opnd << 1;
          aux  <= aux >> 1;
        end
      end
      U_FIX: result <= fix_val;
      default: ;
    endcase
  end

  assign rsp.done   = done;
  assign rsp.result = result;

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == U_IDLE)
    else $error("multiply/divide started while busy");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == U_FIX)
    else $error("done raised without a sign fix cycle");

  a_run_from_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(state == U_RUN) |-> cnt == '0)
    else $error("step count not cleared at start");

endmodule

FILE: sv/register_file_alu_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_file_alu_executor: decoded-instruction executor on a register file
// A small sequencer reads the operands, runs simple operations in place and
// hands multiply, divide and modulo to the shared bit-serial unit, then
// writes back and reads the destination for the result.
// ----------------------------------------------------------------------------
//  channel  valid      stall      payload
//  command  cmd_valid  cmd_stall  cmd  (operation, registers, immediate)
//  result   rsp_valid  rsp_stall  rsp  (value, is_print, divide_by_zero)
//
//  One instruction at a time. Output, unused codes and a zero divisor skip the
//  write-back, exchange writes two registers, and multiply, divide and modulo
//  wait for the shared unit (32 one-bit unit steps). The command side reopens
//  in the same cycle that the result becomes valid, even while that result
//  still waits in the output register. Synchronous reset; all registers read
//  as zero after it, with no clearing pass. A stalled result holds the
//  sequencer only at its final step.
// ----------------------------------------------------------------------------
module register_file_alu_executor #(
  parameter int NUM_REGS = rfx_pkg::NUM_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  rfx_pkg::rfx_in_t  cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rfx_pkg::rfx_out_t rsp
);
  import rfx_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD_AB = 9'b000000010,
    S_RD_D = 9'b000000100,
    S_EXEC = 9'b000001000,
    S_WAIT = 9'b000010000,
    S_WB   = 9'b000100000,
    S_XCH  = 9'b001000000,
    S_RB   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  rfx_in_t           cmd_q;
  logic [DATA_W-1:0] a_q, b_q, dv_q, res_q, alu_res;
  logic              wr_q, prn_q, dz_q, b_zero, fin_go;

  rf_req_t  rf_req;
  rf_rsp_t  rf_rsp;
  mdu_req_t mdu_req;
  mdu_rsp_t mdu_rsp;

  rfx_regs #(
    .NUM_REGS(NUM_REGS)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .req(rf_req),
    .rsp(rf_rsp)
  );

  rfx_mdu u_mdu (
    .clk(clk),
    .rst(rst),
    .req(mdu_req),
    .rsp(mdu_rsp)
  );

  assign cmd_stall = (state != S_IDLE);
  assign b_zero    = (b_q == '0);
  assign fin_go    = !rsp_valid || !rsp_stall;

  always_comb begin
    rf_req.raddr0 = (state == S_RD_AB) ? cmd_q.first_src : cmd_q.dest_reg;
    rf_req.raddr1 = cmd_q.second_src;
    rf_req.we     = (state == S_WB && wr_q) || state == S_XCH;
    rf_req.waddr  = (state == S_XCH) ? cmd_q.first_src : cmd_q.dest_reg;
    rf_req.wdata  = (state == S_XCH) ? dv_q : res_q;

    mdu_req.start    = (state == S_EXEC) &&
                       (cmd_q.operation == OP_MUL ||
                        ((cmd_q.operation == OP_DIV || cmd_q.operation == OP_MOD) &&
                         !b_zero));
    mdu_req.is_div   = (cmd_q.operation != OP_MUL);
    mdu_req.want_rem = (cmd_q.operation == OP_MOD);
    mdu_req.opa      = a_q;
    mdu_req.opb      = b_q;
  end

  always_comb begin
    case (cmd_q.operation)
      OP_LOAD:     alu_res = cmd_q.immediate;
      OP_MOVE:     alu_res = a_q;
      OP_ADD:      alu_res = a_q + b_q;
      OP_SUB:      alu_res = a_q - b_q;
      OP_AND:      alu_res = a_q & b_q;
      OP_OR:       alu_res = a_q | b_q;
      OP_XOR:      alu_res = a_q ^ b_q;
      OP_EXCHANGE: alu_res = a_q;
      default:     alu_res = a_q;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd_valid) state_next = S_RD_AB;
      S_RD_AB: state_next = S_RD_D;
      S_RD_D:  state_next = S_EXEC;
      S_EXEC: begin
        if (cmd_q.operation == OP_MUL) begin
          state_next = S_WAIT;
        end else if (cmd_q.operation inside {OP_DIV, OP_MOD}) begin
          state_next = b_zero ? S_RB : S_WAIT;
        end else if (cmd_q.operation inside {OP_LOAD, OP_MOVE, OP_ADD, OP_SUB,
                                             OP_AND, OP_OR, OP_XOR, OP_EXCHANGE}) begin
          state_next = S_WB;
        end else begin
          state_next = S_RB;
        end
      end
      S_WAIT:  if (mdu_rsp.done) state_next = S_WB;
      S_WB:    state_next = (cmd_q.operation == OP_EXCHANGE) ? S_XCH : S_RB;
      S_XCH:   state_next = S_RB;
      S_RB:    state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && fin_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The result value is always read back from the destination, which covers
  // out-of-range destinations and an exchange of a register with itself.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (cmd_valid) cmd_q <= cmd;
      S_RD_D: begin
        a_q <= rf_rsp.rdata0;
        b_q <= rf_rsp.rdata1;
      end
      S_EXEC: begin
        dv_q  <= rf_rsp.rdata0;
        res_q <= alu_res;
        prn_q <= (cmd_q.operation == OP_OUTPUT);
        dz_q  <= (cmd_q.operation == OP_DIV || cmd_q.operation == OP_MOD) && b_zero;
        wr_q  <= (cmd_q.operation inside {OP_LOAD, OP_MOVE, OP_ADD, OP_SUB, OP_MUL,
                                          OP_AND, OP_OR, OP_XOR, OP_EXCHANGE}) ||
                 ((cmd_q.operation == OP_DIV || cmd_q.operation == OP_MOD) && !b_zero);
      end
      S_WAIT: if (mdu_rsp.done) res_q <= mdu_rsp.result;
      S_FIN: begin
        if (fin_go) begin
          rsp.value          <= rf_rsp.rdata0;
          rsp.is_print       <= prn_q;
          rsp.divide_by_zero <= dz_q;
        end
      end
      default: ;
    endcase
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_print && rsp.divide_by_zero))
    else $error("print and divide-by-zero flagged together");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    mdu_rsp.done |-> state == S_WAIT)
    else $error("multiply/divide result arrived outside wait state");

  a_write_in_writeback: assert property (@(posedge clk) disable iff (rst)
    rf_req.we |-> (state == S_WB || state == S_XCH))
    else $error("register write outside write-back");

  a_dz_only_divide: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && dz_q) |-> (cmd_q.operation == OP_DIV || cmd_q.operation == OP_MOD))
    else $error("divide-by-zero flag on a non-divide operation");

endmodule
